// File: hw/rtl/callback_timer_table_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the callback timer table
// Shorthand for clocked implication checks with an asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef CALLBACK_TIMER_TABLE_CORE_ASSERT_SVH
`define CALLBACK_TIMER_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define CTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CTT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ctt_pkg.sv
// ---------------------------------------------------------------------------
// Callback timer table package
// Field widths, default sizes, command and status codes, and shared types.
// ---------------------------------------------------------------------------
package ctt_pkg;

	localparam int CMD_W    = 3;
	localparam int ID_W     = 8;
	localparam int ARG_W    = 16;
	localparam int DLY_W    = 16;
	localparam int STATUS_W = 3;

	localparam int SLOTS_DEF      = 20;
	localparam int ID_BITS_DEF    = 8;
	localparam int COUNT_BITS_DEF = 24;

	typedef enum logic [CMD_W-1:0] {
		CMD_START_PER = 3'd0,
		CMD_START_ONE = 3'd1,
		CMD_REMOVE    = 3'd2,
		CMD_LENGTHEN  = 3'd3,
		CMD_RUN       = 3'd4
	} ctt_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 3'd0,
		ST_FIRED     = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_NOTHING   = 3'd4
	} ctt_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_FIN
	} ctt_state_t;

	typedef struct packed {
		logic periodic;
		logic positive;
		logic zero;
	} ctt_flags_t;

endpackage

// File: hw/rtl/ctt_req_if.sv
// ---------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one table command per transfer.
// ---------------------------------------------------------------------------
interface ctt_req_if;
	logic                        valid;
	logic                        ready;
	logic [ctt_pkg::CMD_W-1:0]   command;
	logic [ctt_pkg::ID_W-1:0]    callback_id;
	logic signed [ctt_pkg::ARG_W-1:0] argument;
	logic signed [ctt_pkg::DLY_W-1:0] delay;
	logic                        phase;

	modport source (output valid, command, callback_id, argument, delay, phase,
		input ready);
	modport sink (input valid, command, callback_id, argument, delay, phase,
		output ready);
endinterface

// File: hw/rtl/ctt_rsp_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result per transfer.
// ---------------------------------------------------------------------------
interface ctt_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [ctt_pkg::STATUS_W-1:0]   status;
	logic [ctt_pkg::ID_W-1:0]       fired_id;
	logic signed [ctt_pkg::ARG_W-1:0] fired_argument;
	logic                           last;

	modport source (output valid, status, fired_id, fired_argument, last,
		input ready);
	modport sink (input valid, status, fired_id, fired_argument, last,
		output ready);
endinterface

// File: hw/rtl/ctt_alu.sv
// ---------------------------------------------------------------------------
// Callback timer table count unit
// Shared saturating adder and count tests used for every slot visit.
// ---------------------------------------------------------------------------
module ctt_alu #(
	parameter int COUNT_BITS = ctt_pkg::COUNT_BITS_DEF
) (
	input  logic [COUNT_BITS-1:0]           count,
	input  logic                            dec,
	input  logic [ctt_pkg::DLY_W-1:0]       amount,
	output logic [COUNT_BITS-1:0]           sum,
	output ctt_pkg::ctt_flags_t             flags
);
	import ctt_pkg::*;

	logic [COUNT_BITS:0] addend;
	logic [COUNT_BITS:0] wide;

	always_comb begin
		if (dec) begin
			addend = '1;
		end else begin
			addend = {{(COUNT_BITS + 1 - DLY_W){amount[DLY_W-1]}}, amount};
		end
		wide = {count[COUNT_BITS-1], count} + addend;
		if (wide[COUNT_BITS] != wide[COUNT_BITS-1]) begin
			sum = wide[COUNT_BITS] ? {1'b1, {(COUNT_BITS-1){1'b0}}}
				: {1'b0, {(COUNT_BITS-1){1'b1}}};
		end else begin
			sum = wide[COUNT_BITS-1:0];
		end
		flags.periodic = (count == '1);
		flags.positive = !count[COUNT_BITS-1] && (count != '0);
		flags.zero     = (sum == '0);
	end

endmodule

// File: hw/rtl/callback_timer_table_core.sv
// ---------------------------------------------------------------------------
// Callback timer table core
// Slot table of one-shot and periodic callbacks with a sequential scanner.
// ---------------------------------------------------------------------------
// Each start, remove, lengthen or run walks the slot table one slot at a
// time: the slot memory has a single port with a registered read, so each
// visit is a read state and an evaluate state on the shared count unit. A
// start, remove or lengthen stops at the first slot that answers and
// otherwise ends in the finish state. A run scans the table twice, periodic
// slots first and then one-shot slots; unused command codes go straight to
// the finish state. Result backpressure can stall the walk. A new command
// is taken once the previous one has handed its final result to the output
// register. The table is empty after reset and needs no clearing pass.
module callback_timer_table_core #(
	parameter int SLOTS      = ctt_pkg::SLOTS_DEF,
	parameter int ID_BITS    = ctt_pkg::ID_BITS_DEF,
	parameter int COUNT_BITS = ctt_pkg::COUNT_BITS_DEF
) (
	input logic   clk,
	input logic   arst_n,
	ctt_req_if.sink   req,
	ctt_rsp_if.source rsp
);
	import ctt_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EW = 1 + ID_BITS + ARG_W + COUNT_BITS;

	ctt_state_t state_q, state_d;

	logic [IW-1:0]      idx_q;
	logic               pass_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [ID_BITS-1:0] id_q;
	logic [ARG_W-1:0]   arg_q;
	logic [DLY_W-1:0]   dly_q;
	logic               ph_q;
	logic [SLOTS-1:0]   busy_q;

	logic [EW-1:0] mem_q [SLOTS];
	logic [EW-1:0] rd_q;

	logic               pend_valid_q;
	logic [ID_BITS-1:0] pend_id_q;
	logic [ARG_W-1:0]   pend_arg_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ID_W-1:0]     out_id_q;
	logic [ARG_W-1:0]    out_arg_q;
	logic                out_last_q;

	logic                  rd_ph;
	logic [ID_BITS-1:0]    rd_cb;
	logic [ARG_W-1:0]      rd_arg;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [COUNT_BITS-1:0] sum;
	ctt_flags_t            flags;

	logic in_xfer, out_free, slot_busy, last_slot;
	logic hit_free, hit_match, ph_ok, fire0, dec1, fire1;

	logic                  stall, hit_done;
	logic                  mem_we;
	logic [EW-1:0]         mem_wdata;
	logic                  busy_set, busy_clr;
	logic                  out_load;
	logic [STATUS_W-1:0]   out_status_d;
	logic [ID_BITS-1:0]    out_id_d;
	logic [ARG_W-1:0]      out_arg_d;
	logic                  out_last_d;
	logic                  pend_load, pend_clr;

	assign rd_ph  = rd_q[EW-1];
	assign rd_cb  = rd_q[EW-2 -: ID_BITS];
	assign rd_arg = rd_q[COUNT_BITS +: ARG_W];
	assign rd_cnt = rd_q[COUNT_BITS-1:0];

	ctt_alu #(
		.COUNT_BITS(COUNT_BITS)
	) u_alu (
		.count  (rd_cnt),
		.dec    (cmd_q == CMD_RUN),
		.amount (dly_q),
		.sum    (sum),
		.flags  (flags)
	);

	assign in_xfer   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign slot_busy = busy_q[idx_q];
	assign last_slot = (idx_q == IW'(SLOTS - 1));
	assign hit_free  = !slot_busy;
	assign hit_match = slot_busy && (rd_cb == id_q);
	assign ph_ok     = slot_busy && (rd_ph == ph_q);
	assign fire0     = !pass_q && ph_ok && flags.periodic;
	assign dec1      = pass_q && ph_ok && flags.positive;
	assign fire1     = dec1 && flags.zero;

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.fired_id       = out_id_q;
	assign rsp.fired_argument = out_arg_q;
	assign rsp.last           = out_last_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					case (req.command) inside
						CMD_START_PER, CMD_START_ONE, CMD_REMOVE, CMD_LENGTHEN,
						CMD_RUN: state_d = S_RD;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_RD: state_d = S_EV;
			S_EV: begin
				if (stall) begin
					state_d = S_EV;
				end else if (hit_done) begin
					state_d = S_IDLE;
				end else if (last_slot && !(cmd_q == CMD_RUN && !pass_q)) begin
					state_d = S_FIN;
				end else begin
					state_d = S_RD;
				end
			end
			S_FIN: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		stall        = 1'b0;
		hit_done     = 1'b0;
		mem_we       = 1'b0;
		mem_wdata    = {rd_ph, rd_cb, rd_arg, sum};
		busy_set     = 1'b0;
		busy_clr     = 1'b0;
		out_load     = 1'b0;
		out_status_d = ST_DONE;
		out_id_d     = '0;
		out_arg_d    = '0;
		out_last_d   = 1'b1;
		pend_load    = 1'b0;
		pend_clr     = 1'b0;
		case (state_q)
			S_EV: begin
				case (cmd_q) inside
					CMD_START_PER, CMD_START_ONE: begin
						if (hit_free) begin
							if (out_free) begin
								hit_done  = 1'b1;
								mem_we    = 1'b1;
								mem_wdata = {ph_q, id_q, arg_q,
									(cmd_q == CMD_START_PER) ? {COUNT_BITS{1'b1}}
									: {{(COUNT_BITS - DLY_W){dly_q[DLY_W-1]}}, dly_q}};
								busy_set  = 1'b1;
								out_load  = 1'b1;
							end else begin
								stall = 1'b1;
							end
						end
					end
					CMD_REMOVE, CMD_LENGTHEN: begin
						if (hit_match) begin
							if (out_free) begin
								hit_done = 1'b1;
								out_load = 1'b1;
								if (cmd_q == CMD_REMOVE) begin
									busy_clr = 1'b1;
								end else begin
									mem_we = 1'b1;
								end
							end else begin
								stall = 1'b1;
							end
						end
					end
					CMD_RUN: begin
						if (fire0 || fire1) begin
							if (pend_valid_q && !out_free) begin
								stall = 1'b1;
							end else begin
								pend_load = 1'b1;
								busy_clr  = fire1;
								if (pend_valid_q) begin
									out_load     = 1'b1;
									out_status_d = ST_FIRED;
									out_id_d     = pend_id_q;
									out_arg_d    = pend_arg_q;
									out_last_d   = 1'b0;
								end
							end
						end else if (dec1) begin
							mem_we = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			S_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					pend_clr = 1'b1;
					case (cmd_q) inside
						CMD_START_PER, CMD_START_ONE: out_status_d = ST_FULL;
						CMD_REMOVE, CMD_LENGTHEN:     out_status_d = ST_NOT_FOUND;
						CMD_RUN: begin
							if (pend_valid_q) begin
								out_status_d = ST_FIRED;
								out_id_d     = pend_id_q;
								out_arg_d    = pend_arg_q;
							end else begin
								out_status_d = ST_NOTHING;
							end
						end
						default: out_status_d = ST_DONE;
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			pass_q       <= 1'b0;
			busy_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				idx_q  <= '0;
				pass_q <= 1'b0;
			end else if (state_q == S_EV && !stall && !hit_done) begin
				if (last_slot) begin
					idx_q  <= '0;
					pass_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (busy_set) busy_q[idx_q] <= 1'b1;
			if (busy_clr) busy_q[idx_q] <= 1'b0;
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clr) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q <= req.command;
			id_q  <= ID_BITS'(req.callback_id);
			arg_q <= req.argument;
			dly_q <= req.delay;
			ph_q  <= req.phase;
		end
		if (pend_load) begin
			pend_id_q  <= rd_cb;
			pend_arg_q <= rd_arg;
		end
		if (out_load) begin
			out_status_q <= out_status_d;
			out_id_q     <= ID_W'(out_id_d);
			out_arg_q    <= out_arg_d;
			out_last_q   <= out_last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[idx_q] <= mem_wdata;
		if (state_q == S_RD) rd_q <= mem_q[idx_q];
	end

	`include "callback_timer_table_core_assert.svh"

	`CTT_ASSERT_IMP(a_pend_only_run, clk, arst_n, pend_valid_q, cmd_q == CMD_RUN, "pending result outside a run")
	`CTT_ASSERT_IMP(a_idle_no_pend, clk, arst_n, state_q == S_IDLE, !pend_valid_q, "pending result left after a command")
	`CTT_ASSERT_IMP(a_busy_from_ev, clk, arst_n, busy_q != $past(busy_q), $past(state_q) == S_EV, "busy bits changed outside slot evaluation")

endmodule

// File: dv/ctt_timer_checker.sv
// ---------------------------------------------------------------------------
// Callback timer table checker
// Watches the command and result channels, keeps its own copy of the slot
// table, works out the results each accepted command should cause and
// compares every result transfer with the oldest one still awaited.
// ---------------------------------------------------------------------------
module ctt_timer_checker (
	input logic clk,
	input logic arst_n,
	ctt_req_if  req,
	ctt_rsp_if  rsp,
	output int  errors,
	output int  outstanding
);
	import ctt_pkg::*;

	localparam int SLOTS    = SLOTS_DEF;
	localparam int CNT_W    = COUNT_BITS_DEF;
	localparam int CNT_MAX  = (1 << (CNT_W - 1)) - 1;
	localparam int CNT_MIN  = -CNT_MAX - 1;
	localparam int PERIODIC = -1;

	typedef struct packed {
		ctt_status_t             status;
		logic [ID_W-1:0]         id;
		logic signed [ARG_W-1:0] arg;
		logic                    last;
	} callback_result_t;

	logic                    busy     [SLOTS];
	logic                    phase_of [SLOTS];
	logic [ID_W-1:0]         id_of    [SLOTS];
	logic signed [ARG_W-1:0] arg_of   [SLOTS];
	logic signed [CNT_W-1:0] count_of [SLOTS];

	callback_result_t callback_results_q [$];

	function automatic void post_result(ctt_status_t st, logic [ID_W-1:0] id,
			logic signed [ARG_W-1:0] arg);
		callback_result_t r;
		r.status = st;
		r.id     = id;
		r.arg    = arg;
		r.last   = 1'b0;
		callback_results_q.push_back(r);
	endfunction

	function automatic void apply_table_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
			logic signed [ARG_W-1:0] arg, logic signed [DLY_W-1:0] dly, logic ph);
		int slot;
		int fired;
		int sum;
		slot  = -1;
		fired = 0;
		case (cmd)
			CMD_START_PER, CMD_START_ONE: begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!busy[i])
						slot = i;
				if (slot < 0) begin
					post_result(ST_FULL, '0, '0);
				end else begin
					busy[slot]     = 1'b1;
					phase_of[slot] = ph;
					id_of[slot]    = id;
					arg_of[slot]   = arg;
					count_of[slot] = (cmd == CMD_START_PER) ? CNT_W'(PERIODIC) : CNT_W'(dly);
					post_result(ST_DONE, '0, '0);
				end
			end
			CMD_REMOVE, CMD_LENGTHEN: begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (busy[i] && id_of[i] == id)
						slot = i;
				if (slot < 0) begin
					post_result(ST_NOT_FOUND, '0, '0);
				end else begin
					if (cmd == CMD_REMOVE) begin
						busy[slot] = 1'b0;
					end else begin
						sum = int'(count_of[slot]) + int'(dly);
						if (sum > CNT_MAX)
							sum = CNT_MAX;
						if (sum < CNT_MIN)
							sum = CNT_MIN;
						count_of[slot] = CNT_W'(sum);
					end
					post_result(ST_DONE, '0, '0);
				end
			end
			CMD_RUN: begin
				for (int i = 0; i < SLOTS; i++)
					if (busy[i] && phase_of[i] == ph && count_of[i] == PERIODIC) begin
						post_result(ST_FIRED, id_of[i], arg_of[i]);
						fired++;
					end
				for (int i = 0; i < SLOTS; i++)
					if (busy[i] && phase_of[i] == ph && count_of[i] > 0) begin
						count_of[i] = count_of[i] - 1;
						if (count_of[i] == 0) begin
							busy[i] = 1'b0;
							post_result(ST_FIRED, id_of[i], arg_of[i]);
							fired++;
						end
					end
				if (fired == 0)
					post_result(ST_NOTHING, '0, '0);
			end
			default: begin
				post_result(ST_DONE, '0, '0);
			end
		endcase
		callback_results_q[callback_results_q.size() - 1].last = 1'b1;
	endfunction

	initial begin
		errors      = 0;
		outstanding = 0;
		for (int i = 0; i < SLOTS; i++)
			busy[i] = 1'b0;
	end

	always @(posedge clk) begin
		callback_result_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (callback_results_q.size() == 0) begin
					errors++;
					$error("unexpected result transfer: status %0d, fired_id %0d",
						rsp.status, rsp.fired_id);
				end else begin
					want = callback_results_q.pop_front();
					if (rsp.status !== want.status) begin
						errors++;
						$error("status: expected %0d, got %0d", want.status, rsp.status);
					end
					if (rsp.fired_id !== want.id) begin
						errors++;
						$error("fired_id: expected %0d, got %0d", want.id, rsp.fired_id);
					end
					if (rsp.fired_argument !== want.arg) begin
						errors++;
						$error("fired_argument: expected %0d, got %0d", want.arg,
							rsp.fired_argument);
					end
					if (rsp.last !== want.last) begin
						errors++;
						$error("last: expected %0d, got %0d", want.last, rsp.last);
					end
				end
			end
			if (req.valid && req.ready)
				apply_table_command(req.command, req.callback_id, req.argument, req.delay,
					req.phase);
			outstanding = callback_results_q.size();
		end
	end

endmodule

// File: dv/tb_callback_timer_table_core.sv
// ---------------------------------------------------------------------------
// Callback timer table testbench
// Drives directed and random table commands into the core with random gaps
// on both channels and one long result stall, and reports the checker's
// verdict once every awaited result has arrived.
// ---------------------------------------------------------------------------
module tb_callback_timer_table_core;
	import ctt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 55;
	localparam int FILL_ITEMS   = 22;
	localparam int DRAIN_CYCLES = 200;

	localparam logic [ID_W-1:0] ID_POOL [8] = '{8'h00, 8'hFF, 8'h5A, 8'hA5,
		8'h01, 8'h80, 8'h7F, 8'h3C};

	logic clk = 1'b0;
	logic arst_n;
	bit   no_gaps = 1'b0;
	bit   hold_request = 1'b0;
	int   errors;
	int   outstanding;

	ctt_req_if req ();
	ctt_rsp_if rsp ();

	callback_timer_table_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	ctt_timer_checker table_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(99) < 75)
			return ID_POOL[$urandom_range(7)];
		return ID_W'($urandom_range(255));
	endfunction

	task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
			input logic signed [ARG_W-1:0] arg, input logic signed [DLY_W-1:0] dly,
			input logic ph);
		while (!no_gaps && $urandom_range(99) < 26) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid       <= 1'b1;
		req.command     <= cmd;
		req.callback_id <= id;
		req.argument    <= arg;
		req.delay       <= dly;
		req.phase       <= ph;
		do @(posedge clk); while (!req.ready);
	endtask

	initial begin
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp.ready <= no_gaps || ($urandom_range(99) >= 26);
		end
	end

	initial begin
		int roll;
		logic signed [DLY_W-1:0] dly;
		arst_n          <= 1'b0;
		req.valid       <= 1'b0;
		req.command     <= CMD_RUN;
		req.callback_id <= '0;
		req.argument    <= '0;
		req.delay       <= '0;
		req.phase       <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_command(CMD_RUN, 8'h00, 16'sh0, 16'sh0, 1'b0);
		issue_command(CMD_REMOVE, 8'h55, 16'sh0, 16'sh0, 1'b0);
		issue_command(CMD_LENGTHEN, 8'hAA, 16'sh0, 16'sh1, 1'b1);
		issue_command(CMD_START_PER, 8'hFF, 16'sh8000, 16'sh7FFF, 1'b1);
		issue_command(CMD_START_ONE, 8'h00, 16'sh7FFF, 16'sh0001, 1'b0);
		issue_command(CMD_START_ONE, 8'h01, 16'shFFFF, 16'shFFFF, 1'b0);
		issue_command(CMD_START_ONE, 8'h02, 16'sh0000, 16'sh0000, 1'b1);
		issue_command(CMD_START_ONE, 8'h03, 16'sh1234, 16'sh8000, 1'b0);
		issue_command(CMD_START_ONE, 8'h04, 16'shABCD, 16'sh7FFF, 1'b1);
		issue_command(CMD_START_ONE, 8'h05, 16'sh5555, 16'sh0002, 1'b0);
		issue_command(CMD_RUN, 8'h00, 16'sh0, 16'sh0, 1'b0);
		issue_command(CMD_RUN, 8'h00, 16'sh0, 16'sh0, 1'b1);
		issue_command(CMD_LENGTHEN, 8'h02, 16'sh0, 16'shFFFF, 1'b0);
		issue_command(CMD_LENGTHEN, 8'h03, 16'sh0, 16'sh7FFF, 1'b0);
		issue_command(CMD_LENGTHEN, 8'hFF, 16'sh0, 16'sh0003, 1'b0);
		issue_command(CMD_RUN, 8'h00, 16'sh0, 16'sh0, 1'b1);
		issue_command(CMD_REMOVE, 8'h01, 16'sh0, 16'sh0, 1'b0);
		issue_command(CMD_RSVD5, 8'hFF, 16'shFFFF, 16'shFFFF, 1'b1);
		issue_command(CMD_RSVD6, 8'h00, 16'sh0000, 16'sh0000, 1'b0);
		issue_command(CMD_RSVD7, 8'hA5, 16'sh5A5A, 16'shA5A5, 1'b1);
		issue_command(CMD_RUN, 8'h00, 16'sh0, 16'sh0, 1'b0);

		// Fill the table past capacity, then run both phases while the result
		// side holds off so that the core backs up.
		repeat (FILL_ITEMS)
			issue_command($urandom_range(1) ? CMD_START_PER : CMD_START_ONE, pick_id(),
				ARG_W'($urandom), DLY_W'($urandom_range(1, 6)), 1'($urandom_range(1)));
		hold_request = 1'b1;
		issue_command(CMD_RUN, 8'h00, 16'sh0, 16'sh0, 1'b0);
		issue_command(CMD_RUN, 8'h00, 16'sh0, 16'sh0, 1'b1);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			no_gaps = (n >= 20 && n < 45);
			roll = $urandom_range(99);
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: dly = DLY_W'($urandom_range(1, 4));
				6: dly = 16'sh0000;
				7: dly = 16'shFFFF;
				8: dly = DLY_W'($urandom_range(0, 6) - 3);
				default: dly = DLY_W'($urandom);
			endcase
			if (roll < 15)
				issue_command(CMD_START_PER, pick_id(), ARG_W'($urandom), DLY_W'($urandom),
					1'($urandom_range(1)));
			else if (roll < 45)
				issue_command(CMD_START_ONE, pick_id(), ARG_W'($urandom), dly,
					1'($urandom_range(1)));
			else if (roll < 57)
				issue_command(CMD_REMOVE, pick_id(), ARG_W'($urandom), DLY_W'($urandom),
					1'($urandom_range(1)));
			else if (roll < 67)
				issue_command(CMD_LENGTHEN, pick_id(), ARG_W'($urandom), dly,
					1'($urandom_range(1)));
			else if (roll < 95)
				issue_command(CMD_RUN, ID_W'($urandom), ARG_W'($urandom), DLY_W'($urandom),
					1'($urandom_range(1)));
			else
				issue_command(CMD_W'($urandom_range(5, 7)), ID_W'($urandom), ARG_W'($urandom),
					DLY_W'($urandom), 1'($urandom_range(1)));
		end
		no_gaps = 1'b0;
		req.valid <= 1'b0;
		@(posedge clk);

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_callback_timer_table_core: clean");
		else
			$display("tb_callback_timer_table_core: errors");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("tb_callback_timer_table_core: errors");
		$finish;
	end

endmodule
